>>> rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and controller/datapath signal groups for the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CAP_W    = 5;   // width of the active_capacity register
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int USE_W    = 32;
  localparam int TIME_W   = 64;

  // command travels in tuser, key and value in tdata
  localparam int IN_W     = KEY_W + VAL_W;
  localparam int IN_BYTES = (IN_W + 7) / 8;
  localparam int OUT_W    = 1 + VAL_W;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, clear scan state
    logic scan_step;  // examine one entry, advance index
    logic update;     // apply hit / insert, latch result
    logic emit;       // move result into the output register
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cap_zero;   // effective capacity is zero
    logic scan_last;  // current scan index is the last active entry
    logic out_full;   // output register holds an item not taken this cycle
  } lfu_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/lfu_cache_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value cache, LFU replacement with LRU tie break.
// ----------------------------------------------------------------------------
//  channel   direction  fields (low bit first)
//  s_axis    in         tuser: command[0]; tdata: key[31:0], value[63:32]
//  m_axis    out        tdata: hit[0], read_value[32:1]
//  cfg       in         active_capacity[4:0], write strobe only
//
//  An item steps through accept, a sequential tag/victim scan of each active
//  entry in turn, update, and hand-off of the result to the output register;
//  the scan is skipped when the effective capacity is zero. The effective
//  capacity is the active capacity capped at 16.
//  The output register lets the next item enter while a result waits; if that
//  result is still not taken, the next item holds in its last step.
//  After reset all entries are invalid and active capacity is 16.
// ----------------------------------------------------------------------------
module lfu_cache_table
  import lfu_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CAP_W-1:0]       cfg_wdata_i,     // active_capacity
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_BYTES*8-1:0]  s_axis_tdata_i,  // key, value
  input  wire logic                   s_axis_tuser_i,  // command
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_BYTES*8-1:0]      m_axis_tdata_o   // hit, read_value
);

  lfu_cmd_t         ctl;
  lfu_stat_t        stat;
  logic             out_hit;
  logic [VAL_W-1:0] out_value;

  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (ctl)
  );

  lfu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (s_axis_tuser_i),
    .key_i       (s_axis_tdata_i[KEY_W-1:0]),
    .value_i     (s_axis_tdata_i[KEY_W+VAL_W-1:KEY_W]),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_hit_o   (out_hit),
    .out_value_o (out_value)
  );

  assign m_axis_tdata_o = {{(OUT_BYTES*8-OUT_W){1'b0}}, out_value, out_hit};

endmodule
`default_nettype wire

>>> rtl/core/lfu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept, scan active entries one per cycle (none at zero capacity), update, emit.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lfu_stat_t stat_i,
  output lfu_cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.cap_zero ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lfu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry storage, sequential match/free/victim scan, update and output register.
// ----------------------------------------------------------------------------
module lfu_datapath
  import lfu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             cmd_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire lfu_cmd_t         ctl_i,
  output lfu_stat_t             stat_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_hit_o,
  output logic [VAL_W-1:0]      out_value_o
);

  // entry storage
  logic                valid_q [CAPACITY];
  logic [KEY_W-1:0]    key_q   [CAPACITY];
  logic [VAL_W-1:0]    val_q   [CAPACITY];
  logic [USE_W-1:0]    cnt_q   [CAPACITY];
  logic [TIME_W-1:0]   last_q  [CAPACITY];
  logic [TIME_W-1:0]   clock_q;
  logic [CAP_W-1:0]    active_q;

  // item being worked on
  logic                is_put_q;
  logic [KEY_W-1:0]    item_key_q;
  logic [VAL_W-1:0]    item_val_q;

  // scan state
  logic [IDX_W-1:0]    idx_q;
  logic                found_q, free_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q, min_idx_q;
  logic [USE_W-1:0]    min_cnt_q;
  logic [TIME_W-1:0]   min_last_q;

  // pending result and output register
  logic                pend_hit_q;
  logic [VAL_W-1:0]    pend_val_q;
  logic                out_valid_q;
  logic                out_hit_q;
  logic [VAL_W-1:0]    out_val_q;

  logic [CAP_W-1:0]    cap_eff, cfg_cap;
  logic                cur_valid, cur_match, cur_better;
  logic [IDX_W-1:0]    slot;
  logic                touch_en, insert_en, val_we;

  assign cap_eff = (active_q > CAP_W'(CAPACITY)) ? CAP_W'(CAPACITY) : active_q;
  assign cfg_cap = (cfg_wdata_i > CAP_W'(CAPACITY)) ? CAP_W'(CAPACITY) : cfg_wdata_i;

  assign cur_valid  = valid_q[idx_q];
  assign cur_match  = cur_valid && (key_q[idx_q] == item_key_q);
  assign cur_better = (idx_q == '0) ||
                      (cnt_q[idx_q] < min_cnt_q) ||
                      ((cnt_q[idx_q] == min_cnt_q) && (last_q[idx_q] < min_last_q));

  always_comb begin
    stat_o.cap_zero  = (cap_eff == '0);
    stat_o.scan_last = (CAP_W'(idx_q) == (cap_eff - CAP_W'(1)));
    stat_o.out_full  = out_valid_q && !out_ready_i;
  end

  // a put to a new key goes to the first free entry, else the LFU/LRU victim
  assign slot      = found_q ? hit_idx_q : (free_q ? free_idx_q : min_idx_q);
  assign touch_en  = ctl_i.update && found_q;
  assign insert_en = ctl_i.update && is_put_q && !found_q && !stat_o.cap_zero;
  assign val_we    = ctl_i.update && is_put_q && (found_q || !stat_o.cap_zero);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        valid_q[i] <= 1'b0;
      end
      active_q    <= CAP_RESET;
      clock_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
        for (int i = 0; i < CAPACITY; i++) begin
          if (CAP_W'(i) >= cfg_cap) begin
            valid_q[i] <= 1'b0;
          end
        end
      end
      if (ctl_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (ctl_i.scan_step) begin
        idx_q <= idx_q + IDX_W'(1);
        if (cur_match && !found_q) begin
          found_q <= 1'b1;
        end
        if (!cur_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (insert_en) begin
        valid_q[slot] <= 1'b1;
      end
      if (touch_en || insert_en) begin
        clock_q <= clock_q + TIME_W'(1);
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      is_put_q   <= cmd_i;
      item_key_q <= key_i;
      item_val_q <= value_i;
    end
    if (ctl_i.scan_step) begin
      if (cur_match && !found_q) begin
        hit_idx_q <= idx_q;
      end
      if (!cur_valid && !free_q) begin
        free_idx_q <= idx_q;
      end
      if (cur_better) begin
        min_idx_q  <= idx_q;
        min_cnt_q  <= cnt_q[idx_q];
        min_last_q <= last_q[idx_q];
      end
    end
    if (insert_en) begin
      key_q[slot]  <= item_key_q;
      cnt_q[slot]  <= USE_W'(1);
      last_q[slot] <= clock_q;
    end else if (touch_en) begin
      if (cnt_q[slot] != '1) begin
        cnt_q[slot] <= cnt_q[slot] + USE_W'(1);
      end
      last_q[slot] <= clock_q;
    end
    if (val_we) begin
      val_q[slot] <= item_val_q;
    end
    if (ctl_i.update) begin
      pend_hit_q <= found_q;
      pend_val_q <= (!is_put_q && found_q) ? val_q[hit_idx_q] : '0;
    end
    if (ctl_i.emit) begin
      out_hit_q <= pend_hit_q;
      out_val_q <= pend_val_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_value_o = out_val_q;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for lfu_cache_table
// Drives get/put items over the input stream and checks every result item
// against its typed result or a cycle-free model of the LFU cache with LRU
// tie break. A short table of directed items comes first, then random phases
// at several active capacities, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import lfu_pkg::*;

  localparam int N_RANDOM    = 1700;
  localparam int N_DIRECTED  = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = CAPACITY + 4;
  localparam int MAX_SHOWN   = 10;
  localparam int N_FIXED     = 8;
  // capacities of the first random phases, lowest entry first
  localparam logic [N_FIXED*CAP_W-1:0] FIXED_CAPS =
    {5'd4, 5'd8, 5'd17, 5'd2, 5'd31, 5'd1, 5'd0, 5'd16};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rvalue;
  } result_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [CAP_W-1:0] cap;
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             known;
    result_t          res;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CAP_W-1:0]      cfg_wdata;
  logic                  s_valid;
  logic                  s_ready;
  logic [IN_BYTES*8-1:0] s_data;
  logic                  s_user;
  logic                  m_valid;
  logic                  m_ready;
  logic [OUT_BYTES*8-1:0] m_data;

  // model state
  logic              ent_valid [CAPACITY];
  logic [KEY_W-1:0]  ent_key   [CAPACITY];
  logic [VAL_W-1:0]  ent_value [CAPACITY];
  logic [USE_W-1:0]  ent_count [CAPACITY];
  logic [TIME_W-1:0] ent_last  [CAPACITY];
  logic [TIME_W-1:0] use_clk;
  logic [CAP_W-1:0]  cap_reg;

  result_t expected_q [$];
  row_t    dir_rows [N_DIRECTED];
  int      errors = 0;
  int      cycles = 0;
  int      burst_left = 0;

  lfu_cache_table u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_capacity(input logic [CAP_W-1:0] cap);
    return (cap > CAPACITY) ? CAPACITY : int'(cap);
  endfunction

  function automatic void touch_entry(input int idx);
    if (ent_count[idx] != {USE_W{1'b1}}) ent_count[idx] = ent_count[idx] + 1'b1;
    ent_last[idx] = use_clk;
    use_clk = use_clk + 1'b1;
  endfunction

  function automatic result_t cache_predict(input logic cmd, input logic [KEY_W-1:0] key,
                                            input logic [VAL_W-1:0] val);
    int      eff;
    int      hit_idx;
    int      slot;
    logic    found;
    logic    have_free;
    result_t res;
    eff = eff_capacity(cap_reg);
    res = '0;
    found = 1'b0;
    hit_idx = 0;
    for (int i = 0; i < eff; i++) begin
      if (!found && ent_valid[i] && ent_key[i] == key) begin
        found = 1'b1;
        hit_idx = i;
      end
    end
    if (cmd == CMD_GET) begin
      if (found) begin
        res.hit = 1'b1;
        res.rvalue = ent_value[hit_idx];
        touch_entry(hit_idx);
      end
      return res;
    end
    if (eff == 0) return res;
    if (found) begin
      res.hit = 1'b1;
      touch_entry(hit_idx);
      ent_value[hit_idx] = val;
      return res;
    end
    slot = 0;
    have_free = 1'b0;
    for (int i = 0; i < eff; i++) begin
      if (!have_free && !ent_valid[i]) begin
        slot = i;
        have_free = 1'b1;
      end
    end
    if (!have_free) begin
      // lowest count wins, then oldest use; strict compare keeps the lower index
      slot = 0;
      for (int i = 1; i < eff; i++) begin
        if (ent_count[i] < ent_count[slot] ||
            (ent_count[i] == ent_count[slot] && ent_last[i] < ent_last[slot]))
          slot = i;
      end
    end
    ent_valid[slot] = 1'b1;
    ent_key[slot]   = key;
    ent_value[slot] = val;
    ent_count[slot] = USE_W'(1);
    ent_last[slot]  = use_clk;
    use_clk = use_clk + 1'b1;
    return res;
  endfunction

  function automatic row_t item_row(input logic cmd, input logic [KEY_W-1:0] key,
                                    input logic [VAL_W-1:0] val, input logic known,
                                    input logic hit, input logic [VAL_W-1:0] rvalue);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.key = key;
    r.val = val;
    r.known = known;
    r.res.hit = hit;
    r.res.rvalue = rvalue;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CAP_W-1:0] cap);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cap = cap;
    return r;
  endfunction

  task automatic send_request(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val, input logic known,
                              input result_t typed);
    result_t predicted;
    int      gap;
    s_valid <= 1'b1;
    s_data  <= {val, key};
    s_user  <= cmd;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predicted = cache_predict(cmd, key, val);
    expected_q.push_back(known ? typed : predicted);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // sender holds off until every result is back and the scan has settled
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    int eff;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_reg = cap;
    eff = eff_capacity(cap);
    for (int i = eff; i < CAPACITY; i++) ent_valid[i] = 1'b0;
  endtask

  // receiver stall pattern
  initial begin : rx_stall
    rx_mode_e mode;
    int       left;
    int       ph;
    m_ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    ph = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(50, 300);
      end
      left--;
      ph++;
      case (mode)
        RX_OPEN:   m_ready <= 1'b1;
        RX_RANDOM: m_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
        default:   m_ready <= ((ph % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && m_valid && m_ready) begin
      got.hit    = m_data[0];
      got.rvalue = m_data[VAL_W:1];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result item: hit=%0b read_value=%h", got.hit, got.rvalue);
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit || got.rvalue !== want.rvalue) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("mismatch: expected hit=%0b read_value=%h, got hit=%0b read_value=%h",
                     want.hit, want.rvalue, got.hit, got.rvalue);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int               sent;
    int               phase;
    int               phase_len;
    int               eff;
    int               pick;
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_base;
    logic [VAL_W-1:0] val;
    logic [CAP_W-1:0] cap;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i]   = '0;
      ent_value[i] = '0;
      ent_count[i] = '0;
      ent_last[i]  = '0;
    end
    use_clk = '0;
    cap_reg = CAP_RESET;

    // directed table: extremes of key and value, hit and miss for both commands,
    // capacity above the table size, shrink invalidation, zero capacity, eviction
    dir_rows[0]  = item_row(CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    dir_rows[1]  = item_row(CMD_PUT, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 1'b0, 32'h0);
    dir_rows[2]  = item_row(CMD_GET, 32'h0000_0000, 32'hdead_beef, 1'b1, 1'b1, 32'h7fff_ffff);
    dir_rows[3]  = item_row(CMD_PUT, 32'hffff_ffff, 32'h8000_0000, 1'b1, 1'b0, 32'h0);
    dir_rows[4]  = item_row(CMD_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000);
    dir_rows[5]  = item_row(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 32'h0);
    dir_rows[6]  = item_row(CMD_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff);
    dir_rows[7]  = item_row(CMD_GET, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    dir_rows[8]  = cfg_row(5'd31);
    dir_rows[9]  = item_row(CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7fff_ffff);
    dir_rows[10] = cfg_row(5'd1);
    dir_rows[11] = item_row(CMD_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    dir_rows[12] = item_row(CMD_PUT, 32'h0000_0005, 32'h0000_0005, 1'b1, 1'b0, 32'h0);
    dir_rows[13] = item_row(CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    dir_rows[14] = cfg_row(5'd0);
    dir_rows[15] = item_row(CMD_PUT, 32'h0000_0007, 32'h0000_0007, 1'b1, 1'b0, 32'h0);
    dir_rows[16] = item_row(CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, 32'h0);
    dir_rows[17] = cfg_row(5'd2);
    dir_rows[18] = item_row(CMD_PUT, 32'h0000_00a0, 32'h5555_aaaa, 1'b0, 1'b0, 32'h0);
    dir_rows[19] = item_row(CMD_PUT, 32'h0000_00b0, 32'haaaa_5555, 1'b0, 1'b0, 32'h0);
    dir_rows[20] = item_row(CMD_GET, 32'h0000_00a0, 32'h0000_0000, 1'b0, 1'b0, 32'h0);
    dir_rows[21] = item_row(CMD_PUT, 32'h0000_00c0, 32'h0f0f_0f0f, 1'b0, 1'b0, 32'h0);
    dir_rows[22] = item_row(CMD_GET, 32'h0000_00b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0);
    dir_rows[23] = item_row(CMD_GET, 32'h0000_00a0, 32'h0000_0000, 1'b0, 1'b0, 32'h0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_capacity(dir_rows[r].cap);
      else
        send_request(dir_rows[r].cmd, dir_rows[r].key, dir_rows[r].val,
                     dir_rows[r].known, dir_rows[r].res);
    end

    sent = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      if (phase < N_FIXED) cap = FIXED_CAPS[phase*CAP_W +: CAP_W];
      else cap = CAP_W'($urandom_range(0, 31));
      write_capacity(cap);
      eff = eff_capacity(cap);
      key_base = $urandom;
      phase_len = (eff == 0) ? 12 : $urandom_range(40, 120);
      for (int n = 0; n < phase_len; n++) begin
        // small hot set builds up counts, a wider set forces evictions
        pick = $urandom_range(0, 99);
        if (pick < 10) key = $urandom;
        else if (pick < 55) key = key_base + $urandom_range(0, 2);
        else key = key_base + $urandom_range(0, eff + 4);
        cmd = ($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET;
        val = $urandom;
        if ($urandom_range(0, 249) == 0) wait_drained();
        send_request(cmd, key, val, 1'b0, '0);
        if (eff != 0) sent++;
      end
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lfu_pkg.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_datapath.sv
rtl/core/lfu_cache_table.sv
tb/testbench.sv
